>>> hw/rtl/bilinear_gain_schedule_lookup_assert.svh
// Assertion macros for the gain-schedule lookup checker.
// No dependencies; included by the checker file.
`ifndef BILINEAR_GAIN_SCHEDULE_LOOKUP_ASSERT_SVH
`define BILINEAR_GAIN_SCHEDULE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define BGSL_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bgsl assertion failed");

// next-cycle implication
`define BGSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("bgsl assertion failed");

`endif

>>> hw/rtl/bgsl_pkg.sv
// Shared constants and codes for the bilinear gain-schedule lookup.
// No dependencies.
`timescale 1ns / 1ps

package bgsl_pkg;

    localparam int MACH_POINTS = 8;
    localparam int ALT_POINTS  = 8;
    localparam int TABLE_COUNT = 5;
    localparam int IDX_W       = 3;
    localparam int TID_W       = 3;
    localparam int CNT_W       = 4;
    localparam int GAIN_DEPTH  = TABLE_COUNT * ALT_POINTS * MACH_POINTS;
    localparam int GAIN_AW     = $clog2(GAIN_DEPTH);

    typedef enum logic [1:0] {
        OP_LOAD_MACH = 2'd0,
        OP_LOAD_ALT  = 2'd1,
        OP_LOAD_GAIN = 2'd2,
        OP_LOOKUP    = 2'd3
    } t_op;

    localparam logic CFG_MACH_COUNT = 1'b0;
    localparam logic CFG_ALT_COUNT  = 1'b1;

endpackage

>>> hw/rtl/bgsl_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
`timescale 1ns / 1ps

module bgsl_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 8
) (
    input  logic                     i_clk,
    input  logic                     i_wr_en,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_rd_addr];
    end

    assign o_rd_data = r_rd_data;

endmodule

>>> hw/rtl/bgsl_interp.sv
// One linear interpolation step with a bit-serial scaled quotient.
// Uses bgsl_pkg; instantiated by the top level.
`timescale 1ns / 1ps

module bgsl_interp
    import bgsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [31:0] i_lo,
    input  logic signed [31:0] i_hi,
    input  logic signed [31:0] i_zlo,
    input  logic signed [31:0] i_zhi,
    input  logic signed [31:0] i_p,
    output logic               o_done,
    output logic signed [31:0] o_result
);

    typedef enum logic [2:0] {S_IDLE, S_CLAMP, S_PREP, S_ITER, S_FIN} t_state;

    t_state             r_state;
    logic               r_done;
    logic signed [31:0] r_result;
    logic signed [31:0] r_lo, r_hi, r_zlo, r_zhi, r_p, r_pc;
    logic signed [32:0] r_den, r_dz;
    logic        [32:0] r_d, r_e, r_m, r_rem, r_q;
    logic               r_zero, r_neg;
    logic        [5:0]  r_cnt;

    logic signed [31:0] n_pc;
    logic signed [32:0] n_dx;
    logic        [32:0] n_adx, n_ad, n_adz;
    logic        [34:0] n_t, n_d1, n_d2, n_rem;
    logic        [1:0]  n_k;
    logic signed [33:0] n_sum;

    always_comb begin
        if (r_p < r_lo) n_pc = r_lo;
        else if (r_p > r_hi) n_pc = r_hi;
        else n_pc = r_p;

        n_dx  = $signed({r_pc[31], r_pc}) - $signed({r_lo[31], r_lo});
        n_adx = n_dx[32] ? 33'(-n_dx) : 33'(n_dx);
        n_ad  = r_den[32] ? 33'(-r_den) : 33'(r_den);
        n_adz = r_dz[32] ? 33'(-r_dz) : 33'(r_dz);

        // remainder doubles, adds e on a set bit of m, drops by 0, d or 2d
        n_t  = {1'b0, r_rem, 1'b0} + {2'b00, (r_m[32] ? r_e : 33'd0)};
        n_d1 = {2'b00, r_d};
        n_d2 = {1'b0, r_d, 1'b0};
        if (n_t >= n_d2) begin
            n_k   = 2'd2;
            n_rem = n_t - n_d2;
        end else if (n_t >= n_d1) begin
            n_k   = 2'd1;
            n_rem = n_t - n_d1;
        end else begin
            n_k   = 2'd0;
            n_rem = n_t;
        end

        if (r_zero) n_sum = {{2{r_zlo[31]}}, r_zlo};
        else if (r_neg) n_sum = {{2{r_zlo[31]}}, r_zlo} - $signed({1'b0, r_q});
        else n_sum = {{2{r_zlo[31]}}, r_zlo} + $signed({1'b0, r_q});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (i_start) begin
                        r_lo    <= i_lo;
                        r_hi    <= i_hi;
                        r_zlo   <= i_zlo;
                        r_zhi   <= i_zhi;
                        r_p     <= i_p;
                        r_state <= S_CLAMP;
                    end
                end
                S_CLAMP: begin
                    r_pc    <= n_pc;
                    r_den   <= $signed({r_hi[31], r_hi}) - $signed({r_lo[31], r_lo});
                    r_dz    <= $signed({r_zhi[31], r_zhi}) - $signed({r_zlo[31], r_zlo});
                    r_state <= S_PREP;
                end
                S_PREP: begin
                    r_d     <= n_ad;
                    r_e     <= (n_adx > n_ad) ? n_ad : n_adx;
                    r_m     <= n_adz;
                    r_zero  <= (r_den == 33'sd0) || (n_dx == 33'sd0);
                    r_neg   <= r_dz[32] ^ (n_dx[32] ^ r_den[32]);
                    r_rem   <= 33'd0;
                    r_q     <= 33'd0;
                    r_cnt   <= 6'd33;
                    r_state <= S_ITER;
                end
                S_ITER: begin
                    r_rem <= n_rem[32:0];
                    r_q   <= {r_q[31:0], 1'b0} + {31'd0, n_k};
                    r_m   <= {r_m[31:0], 1'b0};
                    r_cnt <= r_cnt - 6'd1;
                    if (r_cnt == 6'd1) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (n_sum[33:31] == 3'b000 || n_sum[33:31] == 3'b111) begin
                        r_result <= n_sum[31:0];
                    end else if (n_sum[33]) begin
                        r_result <= 32'sh8000_0000;
                    end else begin
                        r_result <= 32'sh7fff_ffff;
                    end
                    r_done  <= 1'b1;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

>>> hw/rtl/bilinear_gain_schedule_lookup.sv
// Operation: a load is written to its RAM in the cycle it is accepted. A lookup runs a
// breakpoint scan, then per table RAM reads of the corner gains and three interpolations,
// the shared interpolator's bit-serial quotient setting their length; one word at a time.
// Throughput: lookups one at a time under o_stall; loads one per cycle while o_stall is low.
// Reset: synchronous, clears counts to 8 and control; RAM contents stay undefined.
`timescale 1ns / 1ps

module bilinear_gain_schedule_lookup
    import bgsl_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    input  logic [1:0]         i_op,
    input  logic [2:0]         i_table_id,
    input  logic [2:0]         i_row_index,
    input  logic [2:0]         i_col_index,
    input  logic signed [31:0] i_load_value,
    input  logic signed [31:0] i_mach,
    input  logic signed [31:0] i_altitude,
    output logic               o_valid,
    input  logic               i_stall,
    output logic signed [31:0] o_gain_fg,
    output logic signed [31:0] o_gain_beta,
    output logic signed [31:0] o_gain_beta_rate,
    output logic signed [31:0] o_gain_aileron,
    output logic signed [31:0] o_gain_roll,
    input  logic               i_cfg_wr_en,
    input  logic               i_cfg_index,
    input  logic [3:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_GREAD, ST_M1, ST_M2, ST_ALT, ST_OUT
    } t_state;

    t_state             r_state;
    logic [CNT_W-1:0]   r_mach_count, r_alt_count;
    logic signed [31:0] r_mach, r_alt;
    logic [3:0]         r_idx;
    logic [TID_W-1:0]   r_t;
    logic               r_mfound, r_afound;
    logic [IDX_W-1:0]   r_b, r_a;
    logic signed [31:0] r_mlo, r_mhi, r_alo, r_ahi;
    logic signed [31:0] r_z [4];
    logic signed [31:0] r_m1, r_m2;
    logic signed [31:0] r_res [TABLE_COUNT];
    logic               r_go;
    logic               r_out_valid;
    logic signed [31:0] r_out [TABLE_COUNT];

    logic               n_acc;
    logic [CNT_W-1:0]   n_mc, n_ac;
    logic [IDX_W-1:0]   n_j;
    logic [IDX_W-1:0]   n_row, n_col;
    logic [31:0]        n_mbp_rd, n_abp_rd, n_gain_rd;
    logic signed [31:0] n_lo, n_hi, n_zlo, n_zhi, n_p;
    logic               n_done;
    logic signed [31:0] n_res;

    assign n_acc   = i_valid && !o_stall;
    assign o_stall = (r_state != ST_IDLE);

    always_comb begin
        if (r_mach_count < 4'd2) n_mc = 4'd2;
        else if (r_mach_count > CNT_W'(MACH_POINTS)) n_mc = CNT_W'(MACH_POINTS);
        else n_mc = r_mach_count;
        if (r_alt_count < 4'd2) n_ac = 4'd2;
        else if (r_alt_count > CNT_W'(ALT_POINTS)) n_ac = CNT_W'(ALT_POINTS);
        else n_ac = r_alt_count;
        n_j   = IDX_W'(r_idx - 4'd1);
        n_row = r_idx[1] ? r_a : r_a - 3'd1;
        n_col = r_idx[0] ? r_b : r_b - 3'd1;
    end

    bgsl_ram #(.WIDTH(32), .DEPTH(MACH_POINTS)) u_mach_bp (
        .i_clk     (i_clk),
        .i_wr_en   (n_acc && i_op == OP_LOAD_MACH),
        .i_wr_addr (i_col_index),
        .i_wr_data (i_load_value),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (n_mbp_rd)
    );

    bgsl_ram #(.WIDTH(32), .DEPTH(ALT_POINTS)) u_alt_bp (
        .i_clk     (i_clk),
        .i_wr_en   (n_acc && i_op == OP_LOAD_ALT),
        .i_wr_addr (i_row_index),
        .i_wr_data (i_load_value),
        .i_rd_addr (r_idx[IDX_W-1:0]),
        .o_rd_data (n_abp_rd)
    );

    // table address packs {table, row, col}; rows and cols are powers of two
    bgsl_ram #(.WIDTH(32), .DEPTH(GAIN_DEPTH)) u_gain (
        .i_clk     (i_clk),
        .i_wr_en   (n_acc && i_op == OP_LOAD_GAIN && i_table_id < TID_W'(TABLE_COUNT)),
        .i_wr_addr (GAIN_AW'({i_table_id, i_row_index, i_col_index})),
        .i_wr_data (i_load_value),
        .i_rd_addr (GAIN_AW'({r_t, n_row, n_col})),
        .o_rd_data (n_gain_rd)
    );

    always_comb begin
        case (r_state)
            ST_M1: begin
                n_lo = r_mlo; n_hi = r_mhi; n_zlo = r_z[0]; n_zhi = r_z[1]; n_p = r_mach;
            end
            ST_M2: begin
                n_lo = r_mlo; n_hi = r_mhi; n_zlo = r_z[2]; n_zhi = r_z[3]; n_p = r_mach;
            end
            default: begin
                n_lo = r_alo; n_hi = r_ahi; n_zlo = r_m1; n_zhi = r_m2; n_p = r_alt;
            end
        endcase
    end

    bgsl_interp u_interp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_go),
        .i_lo     (n_lo),
        .i_hi     (n_hi),
        .i_zlo    (n_zlo),
        .i_zhi    (n_zhi),
        .i_p      (n_p),
        .o_done   (n_done),
        .o_result (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_mach_count <= 4'd8;
            r_alt_count  <= 4'd8;
            r_out_valid  <= 1'b0;
            r_go         <= 1'b0;
            r_idx        <= 4'd0;
            r_t          <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                unique case (i_cfg_index)
                    CFG_MACH_COUNT: r_mach_count <= i_cfg_data;
                    CFG_ALT_COUNT:  r_alt_count  <= i_cfg_data;
                    default: ;
                endcase
            end
            if (r_out_valid && !i_stall) begin
                r_out_valid <= 1'b0;
            end
            r_go <= 1'b0;

            unique case (r_state)
                ST_IDLE: begin
                    if (n_acc && i_op == OP_LOOKUP) begin
                        r_mach   <= i_mach;
                        r_alt    <= i_altitude;
                        r_idx    <= 4'd0;
                        r_mfound <= 1'b0;
                        r_afound <= 1'b0;
                        r_state  <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    // read index r_idx issued; data of index r_idx-1 arrives now
                    r_idx <= r_idx + 4'd1;
                    if (r_idx != 4'd0) begin
                        if (!r_mfound) begin
                            if (n_j == '0) begin
                                r_mlo <= n_mbp_rd;
                            end else if ({1'b0, n_j} == n_mc - 4'd1
                                         || $signed(n_mbp_rd) > r_mach) begin
                                r_mfound <= 1'b1;
                                r_mhi    <= n_mbp_rd;
                                r_b      <= n_j;
                            end else begin
                                r_mlo <= n_mbp_rd;
                            end
                        end
                        if (!r_afound) begin
                            if (n_j == '0) begin
                                r_alo <= n_abp_rd;
                            end else if ({1'b0, n_j} == n_ac - 4'd1
                                         || $signed(n_abp_rd) > r_alt) begin
                                r_afound <= 1'b1;
                                r_ahi    <= n_abp_rd;
                                r_a      <= n_j;
                            end else begin
                                r_alo <= n_abp_rd;
                            end
                        end
                    end
                    if (r_idx == 4'd8) begin
                        r_idx   <= 4'd0;
                        r_t     <= '0;
                        r_state <= ST_GREAD;
                    end
                end
                ST_GREAD: begin
                    // corners z11, z12, z21, z22 in read order
                    r_idx <= r_idx + 4'd1;
                    if (r_idx != 4'd0) begin
                        r_z[r_idx[1:0] - 2'd1] <= n_gain_rd;
                    end
                    if (r_idx == 4'd4) begin
                        r_go    <= 1'b1;
                        r_state <= ST_M1;
                    end
                end
                ST_M1: begin
                    if (n_done) begin
                        r_m1    <= n_res;
                        r_go    <= 1'b1;
                        r_state <= ST_M2;
                    end
                end
                ST_M2: begin
                    if (n_done) begin
                        r_m2    <= n_res;
                        r_go    <= 1'b1;
                        r_state <= ST_ALT;
                    end
                end
                ST_ALT: begin
                    if (n_done) begin
                        r_res[r_t] <= n_res;
                        r_idx      <= 4'd0;
                        if (r_t == TID_W'(TABLE_COUNT - 1)) begin
                            r_state <= ST_OUT;
                        end else begin
                            r_t     <= r_t + 3'd1;
                            r_state <= ST_GREAD;
                        end
                    end
                end
                ST_OUT: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out       <= r_res;
                        r_out_valid <= 1'b1;
                        r_state     <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_valid          = r_out_valid;
    assign o_gain_fg        = r_out[0];
    assign o_gain_beta      = r_out[1];
    assign o_gain_beta_rate = r_out[2];
    assign o_gain_aileron   = r_out[3];
    assign o_gain_roll      = r_out[4];

endmodule

>>> hw/rtl/bgsl_checker.sv
// Port-level checker for the gain-schedule lookup, bound to the top level.
// Uses bgsl_pkg and bilinear_gain_schedule_lookup_assert.svh.
`timescale 1ns / 1ps
`include "bilinear_gain_schedule_lookup_assert.svh"

module bgsl_checker
    import bgsl_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_valid,
    input logic        o_stall,
    input logic [1:0]  i_op,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_gain_fg,
    input logic [31:0] o_gain_roll
);

    `BGSL_ASSERT_NEXT(a_out_hold, o_valid && i_stall, o_valid)
    `BGSL_ASSERT_NEXT(a_out_stable, o_valid && i_stall, $stable(o_gain_fg) && $stable(o_gain_roll))
    `BGSL_ASSERT_NEXT(a_lookup_busy, i_valid && !o_stall && i_op == OP_LOOKUP, o_stall)
    `BGSL_ASSERT_NEXT(a_load_free, i_valid && !o_stall && i_op != OP_LOOKUP, !o_stall)

endmodule

bind bilinear_gain_schedule_lookup bgsl_checker u_bgsl_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_valid     (i_valid),
    .o_stall     (o_stall),
    .i_op        (i_op),
    .o_valid     (o_valid),
    .i_stall     (i_stall),
    .o_gain_fg   (o_gain_fg),
    .o_gain_roll (o_gain_roll)
);
